### design/qlt_pkg.sv
// Shared types, constants and helpers for the quoted line tokenizer.
package qlt_pkg;

  localparam int unsigned LINE_COUNT_BITS = 24;
  localparam int unsigned MAX_RESULTS     = 3;

  localparam logic [7:0] MAX_TOKENS = 8'd128;
  localparam logic [LINE_COUNT_BITS-1:0] LINE_MAX = {LINE_COUNT_BITS{1'b1}};

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef enum logic [2:0] {
    KIND_CHAR    = 3'd0,
    KIND_TEND    = 3'd1,
    KIND_LEND    = 3'd2,
    KIND_ABANDON = 3'd3,
    KIND_EOF     = 3'd4
  } kind_t;

  typedef struct packed {
    logic                       at_line_start;
    logic                       in_comment;
    logic                       discarding_rest;
    logic                       held_backslash;
    logic                       in_quote;
    logic                       token_open;
    logic [7:0]                 token_count;
    logic [LINE_COUNT_BITS-1:0] physical_lines;
    logic                       phys_fresh;
    logic                       cont_pending;
  } state_t;

  localparam state_t ST_RESET = '{
    at_line_start:   1'b1,
    in_comment:      1'b0,
    discarding_rest: 1'b0,
    held_backslash:  1'b0,
    in_quote:        1'b0,
    token_open:      1'b0,
    token_count:     8'd0,
    physical_lines:  '0,
    phys_fresh:      1'b1,
    cont_pending:    1'b0
  };

  typedef struct packed {
    kind_t                      kind;
    logic [7:0]                 ch;
    logic [7:0]                 cnt;
    logic [LINE_COUNT_BITS-1:0] line;
  } result_t;

  // All results caused by one input word, in order; cnt of them are real.
  typedef struct packed {
    result_t [MAX_RESULTS-1:0] res;
    logic [1:0]                cnt;
  } bundle_t;

  function automatic logic [LINE_COUNT_BITS-1:0] line_inc(
    input logic [LINE_COUNT_BITS-1:0] x
  );
    return (x == LINE_MAX) ? x : x + 1'b1;
  endfunction

endpackage

### design/qlt_step.sv
// Combinational next-state and result logic for one byte of the tokenizer.
module qlt_step (
  input  qlt_pkg::state_t  st_i,
  input  logic [7:0]       byte_i,
  input  logic             eof_i,
  output qlt_pkg::state_t  st_o,
  output qlt_pkg::bundle_t bundle_o
);
  import qlt_pkg::*;

  typedef struct packed {
    state_t     st;
    logic       emit;
    kind_t      kind;
    logic [7:0] ch;
  } take_t;

  typedef struct packed {
    state_t     st;
    logic       tend;
    logic       lend;
    logic [7:0] cnt;
  } fin_t;

  function automatic state_t open_token(input state_t s);
    state_t r;
    r = s;
    r.token_open = 1'b1;
    if (r.token_count < MAX_TOKENS) begin
      r.token_count = r.token_count + 8'd1;
    end
    return r;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic take_t take_char(input state_t s, input logic [7:0] c);
    take_t r;
    logic  skip;
    r.st   = s;
    r.emit = 1'b0;
    r.kind = KIND_CHAR;
    r.ch   = c;
    skip   = 1'b0;
    if (s.at_line_start) begin
      r.st.at_line_start = 1'b0;
      if (c == CH_HASH) begin
        r.st.in_comment = 1'b1;
        skip = 1'b1;
      end
    end
    if (!skip && !r.st.in_comment) begin
      if (c == CH_QUOTE) begin
        if (!r.st.token_open) begin
          r.st = open_token(r.st);
        end
        r.st.in_quote = !r.st.in_quote;
      end else if (is_space(c) && !r.st.in_quote) begin
        if (r.st.token_open) begin
          r.emit = 1'b1;
          r.kind = KIND_TEND;
          r.ch   = 8'd0;
          r.st.token_open = 1'b0;
        end
      end else begin
        if (!r.st.token_open) begin
          r.st = open_token(r.st);
        end
        r.emit = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic fin_t finish_line(input state_t s);
    fin_t r;
    r.st   = s;
    r.tend = s.token_open;
    r.lend = (s.token_count != 8'd0) && !s.in_comment;
    r.cnt  = s.token_count;
    r.st.at_line_start = 1'b1;
    r.st.in_comment    = 1'b0;
    r.st.in_quote      = 1'b0;
    r.st.token_open    = 1'b0;
    r.st.token_count   = 8'd0;
    return r;
  endfunction

  state_t                    s;
  take_t                     tk;
  fin_t                      fin;
  result_t [MAX_RESULTS-1:0] res;
  logic [1:0]                n;
  logic                      done;

  always_comb begin
    s    = st_i;
    res  = '0;
    n    = 2'd0;
    done = 1'b0;
    tk   = '0;
    fin  = '0;
    if (eof_i) begin
      if (s.held_backslash || s.cont_pending) begin
        s.physical_lines = line_inc(s.physical_lines);
        res[n] = '{kind: KIND_ABANDON, ch: 8'd0, cnt: 8'd0, line: s.physical_lines};
        n = n + 2'd1;
      end else begin
        fin = finish_line(s);
        if (fin.tend) begin
          res[n] = '{kind: KIND_TEND, ch: 8'd0, cnt: 8'd0, line: s.physical_lines};
          n = n + 2'd1;
        end
        if (fin.lend) begin
          res[n] = '{kind: KIND_LEND, ch: 8'd0, cnt: fin.cnt, line: s.physical_lines};
          n = n + 2'd1;
        end
        s.physical_lines = line_inc(s.physical_lines);
      end
      res[n] = '{kind: KIND_EOF, ch: 8'd0, cnt: 8'd0, line: s.physical_lines};
      n = n + 2'd1;
      s = ST_RESET;
    end else if (s.discarding_rest) begin
      if (byte_i == CH_NL) begin
        s.discarding_rest = 1'b0;
        s.phys_fresh      = 1'b1;
      end
    end else begin
      if (s.phys_fresh) begin
        s.physical_lines = line_inc(s.physical_lines);
        s.phys_fresh     = 1'b0;
        s.cont_pending   = 1'b0;
      end
      if (s.held_backslash) begin
        s.held_backslash = 1'b0;
        if ((byte_i == CH_NL) || (byte_i == CH_NUL)) begin
          // line continuation: the backslash and the break vanish
          s.cont_pending = 1'b1;
          if (byte_i == CH_NL) begin
            s.phys_fresh = 1'b1;
          end else begin
            s.discarding_rest = 1'b1;
          end
          done = 1'b1;
        end else begin
          tk = take_char(s, CH_BSL);
          s  = tk.st;
          if (tk.emit) begin
            res[n] = '{kind: tk.kind, ch: tk.ch, cnt: 8'd0, line: s.physical_lines};
            n = n + 2'd1;
          end
        end
      end
      if (!done) begin
        if (byte_i == CH_BSL) begin
          s.held_backslash = 1'b1;
        end else if ((byte_i == CH_NL) || (byte_i == CH_NUL)) begin
          fin = finish_line(s);
          if (fin.tend) begin
            res[n] = '{kind: KIND_TEND, ch: 8'd0, cnt: 8'd0, line: s.physical_lines};
            n = n + 2'd1;
          end
          if (fin.lend) begin
            res[n] = '{kind: KIND_LEND, ch: 8'd0, cnt: fin.cnt, line: s.physical_lines};
            n = n + 2'd1;
          end
          s = fin.st;
          if (byte_i == CH_NL) begin
            s.phys_fresh = 1'b1;
          end else begin
            s.discarding_rest = 1'b1;
          end
        end else begin
          tk = take_char(s, byte_i);
          s  = tk.st;
          if (tk.emit) begin
            res[n] = '{kind: tk.kind, ch: tk.ch, cnt: 8'd0, line: s.physical_lines};
            n = n + 2'd1;
          end
        end
      end
    end
    st_o         = s;
    bundle_o.res = res;
    bundle_o.cnt = n;
  end

endmodule

### design/qlt_res_buf.sv
// Result register: holds one byte's results and hands them out one per word.
module qlt_res_buf (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                load,
  input  qlt_pkg::bundle_t                    bundle_i,
  output logic                                can_load,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [2:0]                          out_result_kind,
  output logic [7:0]                          out_token_char,
  output logic [7:0]                          out_tokens_in_line,
  output logic [qlt_pkg::LINE_COUNT_BITS-1:0] out_line_number,
  output logic                                out_last_of_run
);
  import qlt_pkg::*;

  result_t [MAX_RESULTS-1:0] ent_r, ent_nxt;
  logic [1:0]                cnt_r, cnt_nxt;
  logic                      take;

  assign take     = (cnt_r != 2'd0) && !out_stall;
  assign can_load = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && take);

  always_comb begin
    ent_nxt = ent_r;
    cnt_nxt = cnt_r;
    if (load) begin
      ent_nxt = bundle_i.res;
      cnt_nxt = bundle_i.cnt;
    end else if (take) begin
      ent_nxt[0] = ent_r[1];
      ent_nxt[1] = ent_r[2];
      cnt_nxt    = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    ent_r <= ent_nxt;
  end

  assign out_valid          = (cnt_r != 2'd0);
  assign out_result_kind    = ent_r[0].kind;
  assign out_token_char     = ent_r[0].ch;
  assign out_tokens_in_line = ent_r[0].cnt;
  assign out_line_number    = ent_r[0].line;
  assign out_last_of_run    = (cnt_r == 2'd1);

endmodule

### design/quoted_line_tokenizer_core.sv
// Top level of the quoted line tokenizer: input register, line state, result register.
//
// Usage:
//   Input channel (in_valid / in_stall): one word per byte of text, or a word
//   with in_end_of_file set to close the stream; the byte is then ignored.
//   Output channel (out_valid / out_stall): one word per result, in order.
//   out_last_of_run marks the last result caused by a given input word;
//   input words that cause no result produce nothing on the output.
// Path: an accepted byte is held in the input register, and its results load
//   into the result register once it can take them; the first result is
//   shown from the result register.
// Throughput: one byte per cycle while out_stall is low and each byte gives
//   at most one result. A byte that gives two or three results (line end, end
//   of file, a byte after a held backslash) holds the result register until
//   they drain at one result per unstalled cycle, so that register sets the rate.
// Stall: while the receiver stalls, the shown result holds, the result
//   register fills, and in_stall rises once the input register is also full.
// Reset (rst_n low, synchronous): both registers empty, line state at the
//   start of a fresh stream with the line count at zero. End of file also
//   returns the line state to that starting point.
module quoted_line_tokenizer_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          in_text_byte,
  input  logic                                in_end_of_file,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [2:0]                          out_result_kind,
  output logic [7:0]                          out_token_char,
  output logic [7:0]                          out_tokens_in_line,
  output logic [qlt_pkg::LINE_COUNT_BITS-1:0] out_line_number,
  output logic                                out_last_of_run
);
  import qlt_pkg::*;

  // input register
  logic       in_v_r, in_v_nxt;
  logic [7:0] byte_r;
  logic       eof_r;
  logic       accept;

  // tokenizer state
  state_t  st_r, st_nxt, st_step;
  bundle_t bundle;

  logic can_load;
  logic advance;

  // the held word moves on whenever the result register can take its results
  assign advance  = in_v_r && can_load;
  assign in_stall = in_v_r && !can_load;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    in_v_nxt = in_v_r;
    if (accept) begin
      in_v_nxt = 1'b1;
    end else if (advance) begin
      in_v_nxt = 1'b0;
    end
    st_nxt = advance ? st_step : st_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
      st_r   <= ST_RESET;
    end else begin
      in_v_r <= in_v_nxt;
      st_r   <= st_nxt;
    end
    if (accept) begin
      byte_r <= in_text_byte;
      eof_r  <= in_end_of_file;
    end
  end

  qlt_step u_step (
    .st_i     (st_r),
    .byte_i   (byte_r),
    .eof_i    (eof_r),
    .st_o     (st_step),
    .bundle_o (bundle)
  );

  qlt_res_buf u_res_buf (
    .clk                (clk),
    .rst_n              (rst_n),
    .load               (advance),
    .bundle_i           (bundle),
    .can_load           (can_load),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_result_kind    (out_result_kind),
    .out_token_char     (out_token_char),
    .out_tokens_in_line (out_tokens_in_line),
    .out_line_number    (out_line_number),
    .out_last_of_run    (out_last_of_run)
  );

endmodule

### tb/quoted_line_tokenizer_core_tb.sv
// Self-checking testbench for quoted_line_tokenizer_core: random text stream, line-state predictor.
module quoted_line_tokenizer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import qlt_pkg::*;

  localparam int SETTLE_CYCLES = 6;     // input reg + result reg, with margin
  localparam int TAIL_CYCLES   = 12;
  localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
  localparam int QUIET_LIMIT   = 4000;  // no handshake on either side this long = hung
  localparam int REPORT_MAX    = 10;

  // One input word: a text byte, or end of file when eof is set.
  typedef struct packed {
    logic [7:0] data;
    logic       eof;
  } text_word_t;

  // One expected result word, fields as they appear on the out_ ports.
  typedef struct packed {
    kind_t                      kind;
    logic [7:0]                 ch;
    logic [7:0]                 cnt;
    logic [LINE_COUNT_BITS-1:0] line;
    logic                       last;
  } tok_event_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [7:0]                 in_text_byte = 8'h00;
  logic                       in_end_of_file = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [2:0]                 out_result_kind;
  logic [7:0]                 out_token_char;
  logic [7:0]                 out_tokens_in_line;
  logic [LINE_COUNT_BITS-1:0] out_line_number;
  logic                       out_last_of_run;

  quoted_line_tokenizer_core u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_text_byte       (in_text_byte),
    .in_end_of_file     (in_end_of_file),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_result_kind    (out_result_kind),
    .out_token_char     (out_token_char),
    .out_tokens_in_line (out_tokens_in_line),
    .out_line_number    (out_line_number),
    .out_last_of_run    (out_last_of_run)
  );

  // Words waiting to be sent, and result words still owed by the block.
  text_word_t text_words[$];
  tok_event_t tok_events_due[$];
  tok_event_t step_events[$];   // results of the word being predicted
  int         live_words = 0;   // words queued that the block does not simply skip

  // Traffic knobs: rates and hold request set by the sequencer on the falling edge; hold state by the receiver.
  int snd_idle_pct = 0;
  int rx_stall_pct = 0;
  bit rx_hold_req  = 1'b0;
  bit rx_hold_done = 1'b0;
  int rx_hold_left = 0;

  int bad_results  = 0;
  int quiet_cycles = 0;

  // ---------------------------------------------------------------------
  // Tokenizer state as the predictor sees it
  // ---------------------------------------------------------------------
  logic                       ln_start;      // next char opens a logical line
  logic                       ln_comment;    // logical line began with '#'
  logic                       skip_to_nl;    // after NUL: drop bytes up to newline
  logic                       bsl_held;      // backslash waiting for the next byte
  logic                       quoted;
  logic                       tok_active;
  logic [7:0]                 tok_total;     // saturates at MAX_TOKENS
  logic [LINE_COUNT_BITS-1:0] line_ctr;      // physical lines begun, saturating
  logic                       ln_fresh;      // next byte begins a physical line
  logic                       join_pending;  // continuation taken, next line not begun

  initial forever #10 clk = ~clk;

  task automatic post(input kind_t k, input logic [7:0] c = 8'h00,
                      input logic [7:0] n = 8'h00);
    step_events.push_back('{kind: k, ch: c, cnt: n, line: line_ctr, last: 1'b0});
  endtask

  task automatic bump_line();
    if (line_ctr != LINE_MAX) line_ctr = line_ctr + 1'b1;
  endtask

  task automatic start_token();
    tok_active = 1'b1;
    if (tok_total < MAX_TOKENS) tok_total = tok_total + 8'd1;
  endtask

  task automatic reset_line();
    ln_start   = 1'b1;
    ln_comment = 1'b0;
    quoted     = 1'b0;
    tok_active = 1'b0;
    tok_total  = 8'd0;
  endtask

  // End of a logical line: close the open token, report the count if any.
  task automatic close_line();
    if (tok_active) post(KIND_TEND);
    if (tok_total != 8'd0 && !ln_comment) post(KIND_LEND, 8'h00, tok_total);
    reset_line();
  endtask

  task automatic clear_stream();
    reset_line();
    skip_to_nl   = 1'b0;
    bsl_held     = 1'b0;
    line_ctr     = '0;
    ln_fresh     = 1'b1;
    join_pending = 1'b0;
  endtask

  // One character of logical-line content.
  task automatic feed_char(input logic [7:0] c);
    if (ln_start) begin
      ln_start = 1'b0;
      if (c == CH_HASH) begin
        ln_comment = 1'b1;
        return;
      end
    end
    if (ln_comment) return;
    if (c == CH_QUOTE) begin
      if (!tok_active) start_token();
      quoted = !quoted;
      return;
    end
    if ((c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) && !quoted) begin
      if (tok_active) begin
        post(KIND_TEND);
        tok_active = 1'b0;
      end
      return;
    end
    if (!tok_active) start_token();
    post(KIND_CHAR, c);
  endtask

  // Work out every result one accepted word causes, queue them in order.
  task automatic tokenize_word(input logic [7:0] d, input logic e);
    bit joined;
    step_events.delete();
    if (e) begin
      if (bsl_held || join_pending) begin
        bump_line();
        post(KIND_ABANDON);
      end else begin
        close_line();
        bump_line();
      end
      post(KIND_EOF);
      clear_stream();
    end else if (skip_to_nl) begin
      if (d == CH_NL) begin
        skip_to_nl = 1'b0;
        ln_fresh   = 1'b1;
      end
    end else begin
      if (ln_fresh) begin
        bump_line();
        ln_fresh     = 1'b0;
        join_pending = 1'b0;
      end
      joined = 1'b0;
      if (bsl_held) begin
        bsl_held = 1'b0;
        if (d == CH_NL || d == CH_NUL) begin
          join_pending = 1'b1;
          ln_fresh     = (d == CH_NL);
          skip_to_nl   = (d == CH_NUL);
          joined       = 1'b1;
        end else begin
          feed_char(CH_BSL);
        end
      end
      if (!joined) begin
        if (d == CH_BSL) begin
          bsl_held = 1'b1;
        end else if (d == CH_NL || d == CH_NUL) begin
          close_line();
          ln_fresh   = (d == CH_NL);
          skip_to_nl = (d == CH_NUL);
        end else begin
          feed_char(d);
        end
      end
    end
    if (step_events.size() != 0) step_events[$].last = 1'b1;
    foreach (step_events[i]) tok_events_due.push_back(step_events[i]);
  endtask

  // ---------------------------------------------------------------------
  // Stimulus building blocks
  // ---------------------------------------------------------------------
  task automatic push_word(input logic [7:0] d, input logic e = 1'b0,
                           input bit live = 1'b1);
    text_words.push_back('{data: d, eof: e});
    if (live) live_words++;
  endtask

  task automatic push_str(input string s);
    foreach (s[i]) push_word(s[i]);
  endtask

  task automatic push_eof();
    push_word(8'($urandom_range(255)), 1'b1);
  endtask

  // Ordinary token byte: letters, digits, high bytes, control codes, punctuation.
  function automatic logic [7:0] token_byte();
    logic [7:0] c;
    case ($urandom_range(5))
      0, 1: c = 8'h61 + 8'($urandom_range(25));
      2:    c = 8'h30 + 8'($urandom_range(9));
      3:    c = 8'h80 + 8'($urandom_range(127));
      4: begin
        c = 8'($urandom_range(1, 26));
        if (c > 8'd8) c = c + 8'd5;   // skip 09..0D, land in 0E..1F
      end
      default: begin
        c = 8'h21 + 8'($urandom_range(93));
        if (c == CH_QUOTE || c == CH_BSL) c = CH_HASH;
      end
    endcase
    return c;
  endfunction

  function automatic logic [7:0] blank_byte();
    logic [7:0] c;
    case ($urandom_range(5))
      0, 1, 2: c = CH_SPACE;
      3:       c = CH_TAB;
      4:       c = CH_CR;
      default: c = 8'h0B + 8'($urandom_range(1));   // VT or FF
    endcase
    return c;
  endfunction

  task automatic push_plain(input int n);
    repeat (n) push_word(token_byte());
  endtask

  // Rest of a physical line after NUL: skipped bytes, then the newline.
  task automatic push_junk();
    logic [7:0] d;
    repeat ($urandom_range(3)) begin
      d = 8'($urandom_range(255));
      if (d == CH_NL) d = CH_NUL;
      push_word(d, 1'b0, 1'b0);
    end
    push_word(CH_NL, 1'b0, 1'b0);
  endtask

  task automatic push_token();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: push_plain($urandom_range(1, 5));
      5, 6: begin
        push_word(CH_QUOTE);
        repeat ($urandom_range(4))
          push_word(($urandom_range(2) == 0) ? blank_byte() : token_byte());
        push_word(CH_QUOTE);
        if ($urandom_range(1) != 0) push_plain(1);
      end
      7: begin
        push_word(CH_QUOTE);
        push_word(CH_QUOTE);
      end
      8: begin
        // backslash not before a line end is just a character
        push_plain(1);
        push_word(CH_BSL);
        if ($urandom_range(1) != 0) push_word(CH_BSL);
        push_plain(1);
      end
      default: begin
        // continuation inside a token joins its halves
        push_plain(1);
        push_word(CH_BSL);
        push_word(CH_NL);
        push_plain(1);
      end
    endcase
  endtask

  // One random logical line, mostly well formed, some noise and broken ends.
  task automatic gen_line();
    int r;
    r = $urandom_range(99);
    if (r < 55) begin
      if ($urandom_range(3) == 0) push_word(blank_byte());
      repeat ($urandom_range(1, 6)) begin
        push_token();
        case ($urandom_range(7))
          0: begin
            push_word(CH_BSL);
            push_word(CH_NL);
            push_word(blank_byte());
          end
          1: begin
            // continuation by NUL: rest of the physical line is dropped
            push_word(CH_BSL);
            push_word(CH_NUL);
            push_junk();
            push_word(blank_byte());
          end
          default: repeat ($urandom_range(1, 2)) push_word(blank_byte());
        endcase
      end
      case ($urandom_range(9))
        0: begin
          push_word(CH_NUL);
          push_junk();
        end
        1:       push_eof();
        default: push_word(CH_NL);
      endcase
    end else if (r < 65) begin
      push_word(CH_HASH);
      push_plain($urandom_range(4));
      if ($urandom_range(3) == 0) begin
        push_word(CH_BSL);
        push_word(CH_NL);
        if ($urandom_range(2) == 0) begin
          push_eof();          // continuation still pending inside a comment
          return;
        end
        push_plain(2);
      end
      push_word(CH_NL);
    end else if (r < 73) begin
      repeat ($urandom_range(1, 3)) push_word(blank_byte());
      push_word(CH_NL);
    end else if (r < 80) begin
      // quote never closed: token runs to the end of the line
      push_word(CH_QUOTE);
      push_plain($urandom_range(1, 3));
      push_word(blank_byte());
      push_plain(1);
      push_word(($urandom_range(1) != 0) ? CH_NL : CH_NUL);
    end else if (r < 88) begin
      repeat ($urandom_range(1, 12)) push_word(8'($urandom_range(255)));
    end else if (r < 94) begin
      push_plain($urandom_range(1, 3));
      push_word(CH_BSL);
      case ($urandom_range(2))
        0: ;                   // held backslash at end of file
        1: push_word(CH_NL);
        default: begin
          push_word(CH_NUL);
          push_word(8'($urandom_range(11, 255)), 1'b0, 1'b0);
        end
      endcase
      push_eof();
    end else begin
      push_eof();
    end
  endtask

  task automatic feed_random(input int n);
    int goal;
    goal = live_words + n;
    while (live_words < goal) gen_line();
  endtask

  // More tokens than the count can hold, so it saturates.
  task automatic push_crowded_line();
    repeat (int'(MAX_TOKENS) + 2) begin
      push_plain(1);
      push_word(CH_SPACE);
    end
    push_word(CH_NL);
  endtask

  // Sender stops until every owed result word is in, then a short settle.
  task automatic drain_all();
    do @(negedge clk);
    while (text_words.size() != 0 || in_valid || tok_events_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Driver: presents queued words, predicts each one as it is taken.
  // Valid only drops after an accept, never because of a stall.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : drive_text
    text_word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) tokenize_word(in_text_byte, in_end_of_file);
      if (!in_valid || !in_stall) begin
        if (text_words.size() != 0 &&
            !(snd_idle_pct != 0 && $urandom_range(99) < snd_idle_pct)) begin
          w = text_words.pop_front();
          in_valid       <= 1'b1;
          in_text_byte   <= w.data;
          in_end_of_file <= w.eof;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver backpressure: random stalls, plus one long hold-off on request.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : drive_stall
    if (!rst_n) begin
      out_stall    <= 1'b0;
      rx_hold_left <= 0;
    end else if (rx_hold_left > 0) begin
      out_stall    <= 1'b1;
      rx_hold_left <= rx_hold_left - 1;
      if (rx_hold_left == 1) rx_hold_done <= 1'b1;
    end else if (rx_hold_req && !rx_hold_done) begin
      out_stall    <= 1'b1;
      rx_hold_left <= HOLD_CYCLES;
    end else begin
      out_stall <= (rx_stall_pct != 0 && $urandom_range(99) < rx_stall_pct);
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: each accepted result word against the oldest expectation.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    tok_event_t got;
    tok_event_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{kind: kind_t'(out_result_kind), ch: out_token_char,
              cnt: out_tokens_in_line, line: out_line_number, last: out_last_of_run};
      if (tok_events_due.size() == 0) begin
        bad_results++;
        if (bad_results <= REPORT_MAX)
          $display("%0t: unexpected result kind=%0d char=%02h count=%0d line=%0d last=%0b",
                   $time, got.kind, got.ch, got.cnt, got.line, got.last);
      end else begin
        want = tok_events_due.pop_front();
        if (got !== want) begin
          bad_results++;
          if (bad_results <= REPORT_MAX)
            $display({"%0t: result mismatch: expected kind=%0d char=%02h count=%0d ",
                      "line=%0d last=%0b, got kind=%0d char=%02h count=%0d line=%0d last=%0b"},
                     $time, want.kind, want.ch, want.cnt, want.line, want.last,
                     got.kind, got.ch, got.cnt, got.line, got.last);
        end
      end
    end
  end

  // Watchdog: any handshake on either side clears the count.
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles < QUIET_LIMIT) begin
      quiet_cycles <= quiet_cycles + 1;
    end else begin
      $display("%0t: watchdog: no word moved for %0d cycles", $time, QUIET_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer: reset, then phases with different traffic shapes.
  // ---------------------------------------------------------------------
  initial begin
    clear_stream();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty quote pair, high byte, plain backslash.
    push_str("\"\" ");
    push_word(8'hFF);
    push_str("\\q\n");
    // comment line, blank-only line
    push_str("#x\n");
    push_str("\t\n");
    // continuation joins "a" and "b"; NUL ends the line, rest skipped
    push_str("a\\\nb");
    push_word(CH_NUL);
    push_word(8'h7A, 1'b0, 1'b0);
    push_word(CH_NL, 1'b0, 1'b0);
    // unclosed quote cut by end of file; then backslash held at end of file
    push_str("\"u v");
    push_word(8'h00, 1'b1);
    push_str("\\");
    push_word(8'hFF, 1'b1);

    // No idling at all.
    feed_random(20);
    drain_all();

    // Sender idle most cycles; pause mid-phase until all results are in.
    snd_idle_pct = 63;
    feed_random(15);
    drain_all();
    feed_random(15);
    drain_all();

    // Receiver stalling most cycles; includes the saturating token count.
    snd_idle_pct = 0;
    rx_stall_pct = 63;
    feed_random(20);
    push_crowded_line();
    feed_random(15);
    drain_all();

    // Both sides idling lightly.
    snd_idle_pct = 20;
    rx_stall_pct = 20;
    feed_random(30);
    drain_all();

    // Long receiver hold-off while the sender keeps offering: block fills.
    snd_idle_pct = 0;
    rx_stall_pct = 0;
    feed_random(35);
    rx_hold_req = 1'b1;
    while (!rx_hold_done) @(negedge clk);
    push_eof();
    drain_all();

    repeat (TAIL_CYCLES) @(negedge clk);
    if (bad_results == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### files.f
design/qlt_pkg.sv
design/qlt_step.sv
design/qlt_res_buf.sv
design/quoted_line_tokenizer_core.sv
tb/quoted_line_tokenizer_core_tb.sv
